// ----- sv/itawr_pkg.sv -----
// Package for the IMU triad alignment block: widths, codes, reset values.
// No dependencies.
`default_nettype none
package itawr_pkg;
    localparam int WINDOW_DEF = 64;
    localparam int VW = 20;
    localparam int RW = 19;
    localparam int SW = 46;
    localparam logic [1:0] KIND_ACCEL = 2'd0;
    localparam logic [1:0] KIND_GYRO  = 2'd1;
    localparam logic [1:0] KIND_MAG   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;
    localparam logic [2:0] REG_ROT0 = 3'd0;
    localparam logic [2:0] REG_ROT1 = 3'd1;
    localparam logic [2:0] REG_ROT2 = 3'd2;
    localparam logic [2:0] REG_ABIAS = 3'd3;
    localparam logic [2:0] REG_GBIAS = 3'd4;
    localparam logic [2:0] REG_MBIAS = 3'd5;
    localparam logic [2:0] REG_SCALE = 3'd6;
    localparam logic [53:0] ROT0_RST = 54'd65536;
    localparam logic [53:0] ROT1_RST = 54'd65536 << 18;
    localparam logic [53:0] ROT2_RST = 54'd65536 << 36;
    localparam logic [15:0] SCALE_RST = 16'd40167;
endpackage
`default_nettype wire

// ----- sv/itawr_if.sv -----
// Valid/ready channel interfaces for input, result and configuration.
// Depends on nothing.
`default_nettype none
interface itawr_in_if;
    logic valid;
    logic ready;
    logic [1:0] kind;
    logic signed [19:0] axis_a;
    logic signed [19:0] axis_b;
    logic signed [19:0] axis_c;
    modport source (output valid, kind, axis_a, axis_b, axis_c, input ready);
    modport sink (input valid, kind, axis_a, axis_b, axis_c, output ready);
endinterface

interface itawr_out_if;
    logic valid;
    logic ready;
    logic [1:0] out_kind;
    logic signed [19:0] value_x;
    logic signed [19:0] value_y;
    logic signed [19:0] value_z;
    logic [18:0] rms_x;
    logic [18:0] rms_y;
    logic [18:0] rms_z;
    logic rms_valid;
    modport source (output valid, out_kind, value_x, value_y, value_z, rms_x, rms_y, rms_z,
        rms_valid, input ready);
    modport sink (input valid, out_kind, value_x, value_y, value_z, rms_x, rms_y, rms_z,
        rms_valid, output ready);
endinterface

interface itawr_cfg_if;
    logic valid;
    logic ready;
    logic [2:0] index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- sv/itawr_div.sv -----
// Restoring divider and floor square root, one bit per cycle, shared unit.
// Uses itawr_pkg.
`default_nettype none
module itawr_div
    import itawr_pkg::*;
#(
    parameter int NW = SW
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_start,
    input  wire [NW-1:0] i_num,
    input  wire [10:0]   i_den,
    output logic         o_done,
    output logic [RW-1:0] o_root
);
    localparam int HW = NW / 2;
    localparam int CNTW = $clog2(NW);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001, S_DIV = 3'b010, S_SQRT = 3'b100
    } t_state;
    t_state r_state, n_state;
    logic [NW-1:0] r_q, n_q;
    logic [NW-1:0] r_rem, n_rem;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [HW:0] r_root, n_root;
    logic [HW+2:0] r_srem, n_srem;
    logic [NW:0] w_trial;
    logic [HW+2:0] w_strial;

    always_comb begin
        n_state = r_state;
        n_q = r_q;
        n_rem = r_rem;
        n_cnt = r_cnt;
        n_root = r_root;
        n_srem = r_srem;
        o_done = 1'b0;
        w_trial = '0;
        w_strial = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_q = i_num;
                    n_rem = '0;
                    n_cnt = CNTW'(NW - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                w_trial = {r_rem, r_q[NW-1]} - {{(NW-10){1'b0}}, i_den};
                n_q = {r_q[NW-2:0], ~w_trial[NW]};
                n_rem = w_trial[NW] ? {r_rem[NW-2:0], r_q[NW-1]} : w_trial[NW-1:0];
                if (r_cnt == '0) begin
                    n_cnt = CNTW'(HW - 1);
                    n_root = '0;
                    n_srem = '0;
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_SQRT: begin
                w_strial = {r_srem[HW:0], r_q[NW-1:NW-2]} - {r_root, 2'b01};
                n_q = {r_q[NW-3:0], 2'b00};
                if (!w_strial[HW+2]) begin
                    n_srem = w_strial;
                    n_root = {r_root[HW-1:0], 1'b1};
                end else begin
                    n_srem = {r_srem[HW:0], r_q[NW-1:NW-2]};
                    n_root = {r_root[HW-1:0], 1'b0};
                end
                if (r_cnt == '0) n_state = S_IDLE;
                else n_cnt = r_cnt - 1'b1;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SQRT && r_cnt == '0) o_done = 1'b1;
    end

    always_comb begin
        if (|n_root[HW:RW]) o_root = '1;
        else o_root = n_root[RW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
        r_q <= n_q;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_root <= n_root;
        r_srem <= n_srem;
    end
endmodule
`default_nettype wire

// ----- sv/imu_triad_align_window_rms.sv -----
// One triad at a time: an input is taken only while idle and no result is waiting.
// The shared bit-serial divider/square root unit runs once per axis for an accelerometer,
// gyro or magnetometer triad once three samples are held; fewer than three samples skip it.
// A kind-three input produces its result straight from the idle state.
// Synchronous active-low reset restores configuration defaults and clears sums, fill
// counts and write slots; the window memory is not cleared.
`default_nettype none
module imu_triad_align_window_rms
    import itawr_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  wire i_clk,
    input  wire i_rst_n,
    itawr_in_if.sink   i_in,
    itawr_out_if.source o_out,
    itawr_cfg_if.sink  i_cfg
);
    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);
    // Sum of squares width: holds WINDOW squared 20-bit samples, kept even for the root.
    localparam int SUMW = 2 * ((40 + $clog2(WINDOW)) / 2);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001, S_SCALE = 9'b000000010, S_ROT = 9'b000000100,
        S_ACC = 9'b000001000, S_RD = 9'b000010000, S_UPD = 9'b000100000,
        S_DIV = 9'b001000000, S_WAIT = 9'b010000000, S_OUT = 9'b100000000
    } t_state;
    t_state r_state;

    // Configuration registers.
    logic [53:0] r_rot [3];
    logic [59:0] r_bias [3];
    logic [15:0] r_scale;

    // Per-kind window bookkeeping and the nine sums of squares.
    logic [SUMW-1:0] r_sum [9];
    logic [CW-1:0] r_fill [3];
    logic [AW-1:0] r_slot [3];

    // Window memory: one triad per entry, addressed by kind and slot.
    logic [59:0] r_mem [3*WINDOW];
    logic [59:0] r_old;

    logic [1:0] r_kind;
    logic signed [19:0] r_a, r_b, r_c;
    logic signed [24:0] r_v [3];
    logic signed [42:0] r_prod [3];
    logic [1:0] r_row;
    logic signed [19:0] r_r [3];
    logic [1:0] r_ax;
    logic [RW-1:0] r_rms [3];
    logic r_rvalid;
    logic r_out_valid;
    logic r_start;

    logic [$clog2(3*WINDOW)-1:0] w_addr;
    logic [CW-1:0] w_fill_new;
    logic signed [19:0] w_old_ax [3];
    logic signed [17:0] w_coef [3];
    logic signed [45:0] w_acc;
    logic w_done;
    logic [RW-1:0] w_root;
    logic [3:0] w_si;

    function automatic logic signed [24:0] rnd12(input logic signed [36:0] p);
        logic signed [36:0] t;
        t = p + 37'sd2048;
        return 25'(t >>> 12);
    endfunction

    function automatic logic signed [19:0] sat(input logic signed [45:0] v);
        if (v > 46'sd524287) return 20'sh7FFFF;
        if (v < -46'sd524288) return 20'sh80000;
        return 20'(v);
    endfunction

    assign w_addr = ($clog2(3*WINDOW))'(r_kind * WINDOW) + ($clog2(3*WINDOW))'(r_slot[r_kind]);
    assign w_fill_new = (r_fill[r_kind] >= CW'(WINDOW)) ? r_fill[r_kind] : r_fill[r_kind] + 1'b1;
    assign w_si = 4'(r_kind * 3) + 4'(r_ax);
    assign w_acc = 46'(r_prod[0]) + 46'(r_prod[1]) + 46'(r_prod[2]);
    for (genvar g = 0; g < 3; g++) begin : g_ax
        assign w_old_ax[g] = r_old[20*g +: 20];
        assign w_coef[g] = r_rot[r_row][18*g +: 18];
    end

    // The fill count is already updated when the divider starts, so it is the divisor
    // plus one.
    itawr_div #(.NW(SUMW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_num(r_sum[w_si]), .i_den(11'(r_fill[r_kind] - 1'b1)),
        .o_done(w_done), .o_root(w_root)
    );

    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.out_kind = r_kind;
    assign o_out.value_x = r_r[0];
    assign o_out.value_y = r_r[1];
    assign o_out.value_z = r_r[2];
    assign o_out.rms_x = r_rms[0];
    assign o_out.rms_y = r_rms[1];
    assign o_out.rms_z = r_rms[2];
    assign o_out.rms_valid = r_rvalid;

    // Memory read and write ports.
    always_ff @(posedge i_clk) begin
        if (r_state == S_ACC && r_row == 2'd3) r_old <= r_mem[w_addr];
        if (r_state == S_UPD) r_mem[w_addr] <= {r_r[2], r_r[1], r_r[0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
            r_rot[0] <= ROT0_RST;
            r_rot[1] <= ROT1_RST;
            r_rot[2] <= ROT2_RST;
            for (int k = 0; k < 3; k++) begin
                r_bias[k] <= '0;
                r_fill[k] <= '0;
                r_slot[k] <= '0;
            end
            for (int k = 0; k < 9; k++) r_sum[k] <= '0;
            r_scale <= SCALE_RST;
        end else begin
            // The divider is started for one cycle after each S_DIV cycle.
            r_start <= (r_state == S_DIV);
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_ROT0: r_rot[0] <= i_cfg.data[53:0];
                    REG_ROT1: r_rot[1] <= i_cfg.data[53:0];
                    REG_ROT2: r_rot[2] <= i_cfg.data[53:0];
                    REG_ABIAS: r_bias[0] <= i_cfg.data[59:0];
                    REG_GBIAS: r_bias[1] <= i_cfg.data[59:0];
                    REG_MBIAS: r_bias[2] <= i_cfg.data[59:0];
                    REG_SCALE: r_scale <= i_cfg.data[15:0];
                    default: ;
                endcase
            end
            if (r_out_valid && o_out.ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid && i_in.ready) begin
                        r_kind <= i_in.kind;
                        r_a <= i_in.axis_a;
                        r_b <= i_in.axis_b;
                        r_c <= i_in.axis_c;
                        if (i_in.kind == KIND_NONE) begin
                            for (int k = 0; k < 3; k++) begin
                                r_r[k] <= '0;
                                r_rms[k] <= '0;
                            end
                            r_rvalid <= 1'b0;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_state <= S_SCALE;
                        end
                    end
                end
                S_SCALE: begin
                    // Accelerometer remap and scale, then bias removal; other kinds get bias removal only.
                    if (r_kind == KIND_ACCEL) begin
                        r_v[0] <= rnd12($signed({1'b0, r_scale}) * r_b)
                            - 25'(signed'(r_bias[0][19:0]));
                        r_v[1] <= rnd12(-($signed({1'b0, r_scale}) * r_a))
                            - 25'(signed'(r_bias[0][39:20]));
                        r_v[2] <= rnd12($signed({1'b0, r_scale}) * r_c)
                            - 25'(signed'(r_bias[0][59:40]));
                    end else begin
                        r_v[0] <= 25'(r_a) - 25'(signed'(r_bias[r_kind][19:0]));
                        r_v[1] <= 25'(r_b) - 25'(signed'(r_bias[r_kind][39:20]));
                        r_v[2] <= 25'(r_c) - 25'(signed'(r_bias[r_kind][59:40]));
                    end
                    r_row <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    // One rotation row per pass: three products, then the sum; the magnetometer skips the rotation.
                    if (r_kind == KIND_MAG) begin
                        for (int k = 0; k < 3; k++) r_r[k] <= sat(46'(r_v[k]));
                        r_row <= 2'd3;
                        r_state <= S_ACC;
                    end else begin
                        for (int k = 0; k < 3; k++) r_prod[k] <= 43'(w_coef[k] * r_v[k]);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_row == 2'd3) begin
                        r_state <= S_RD;
                    end else begin
                        r_r[r_row] <= sat(46'((w_acc + 46'sd32768) >>> 16));
                        r_row <= r_row + 2'd1;
                        r_state <= (r_row == 2'd2) ? S_ACC : S_ROT;
                    end
                end
                S_RD: r_state <= S_UPD;
                S_UPD: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sum[r_kind*3+k] <= r_sum[r_kind*3+k]
                            - ((r_fill[r_kind] >= CW'(WINDOW))
                                ? SUMW'(unsigned'(40'(w_old_ax[k] * w_old_ax[k]))) : '0)
                            + SUMW'(unsigned'(40'(r_r[k] * r_r[k])));
                    end
                    r_fill[r_kind] <= w_fill_new;
                    r_slot[r_kind] <= (32'(r_slot[r_kind]) + 1 >= WINDOW) ? '0
                        : r_slot[r_kind] + 1'b1;
                    r_ax <= '0;
                    if (w_fill_new > CW'(2)) begin
                        r_rvalid <= 1'b1;
                        r_state <= S_DIV;
                    end else begin
                        r_rvalid <= 1'b0;
                        for (int k = 0; k < 3; k++) r_rms[k] <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_DIV: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_rms[r_ax] <= w_root;
                        r_ax <= r_ax + 2'd1;
                        r_state <= (r_ax == 2'd2) ? S_OUT : S_DIV;
                    end
                end
                S_OUT: begin
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
